### hw/rtl/dlc_pkg.sv
// dlc_pkg: shared types for the direct linear convolution block.
// Field types, action codes, controller/datapath command and status.
// No dependencies.
`timescale 1ns / 1ps

package dlc_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_PUSH  = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef logic [4:0]         tap_index_t;
  typedef logic [5:0]         tap_count_t;
  typedef logic signed [15:0] sample_t;
  typedef logic signed [31:0] product_t;
  typedef logic signed [39:0] acc_t;

  typedef struct packed {
    logic take;
    logic load_tap;
    logic issue;
    logic finish;
  } dlc_cmd_t;

  typedef struct packed {
    logic last_issue;
    logic acc_done;
    logic out_free;
  } dlc_stat_t;

endpackage

### hw/rtl/dlc_if.sv
// dlc_item_if and dlc_result_if: valid/ready channels of the convolution block.
// Depends on dlc_pkg.
`timescale 1ns / 1ps

interface dlc_item_if import dlc_pkg::*; ();
  logic       valid;
  logic       ready;
  action_t    action;
  tap_index_t tap_index;
  sample_t    value;
  logic       first_of_signal;

  modport source (output valid, action, tap_index, value, first_of_signal, input ready);
  modport sink   (input valid, action, tap_index, value, first_of_signal, output ready);
endinterface

interface dlc_result_if import dlc_pkg::*; ();
  logic valid;
  logic ready;
  acc_t out_value;

  modport source (output valid, out_value, input ready);
  modport sink   (input valid, out_value, output ready);
endinterface

### hw/rtl/direct_linear_convolution.sv
// direct_linear_convolution: top level, sequential FIR convolution block.
// Instantiates dlc_ctrl and dlc_datapath. Depends on dlc_pkg, dlc_if.
//
//   channel  kind          handshake        payload
//   items    item input    valid/ready      action, tap_index, value, first_of_signal
//   results  result out    valid/ready      out_value
//   cfg      register wr   cfg_we           cfg_wdata (tap_count)
//
// A push or flush sums over T taps, T the effective tap count: one shared
// multiply-accumulate unit walks the kernel one tap per cycle behind a
// registered memory read and a registered product. A load or unused code is handled in idle.
// Reset clears control, history valid bits and sets tap_count to 1.
// A finished sum waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps

module direct_linear_convolution import dlc_pkg::*; #(
  parameter int MAX_TAPS = 32
) (
  input  logic             clk,
  input  logic             rst,
  dlc_item_if.sink         items,
  dlc_result_if.source     results,
  input  logic             cfg_we,
  input  tap_count_t       cfg_wdata
);

  dlc_cmd_t  cmd;
  dlc_stat_t stat;

  dlc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_ready (items.ready),
    .action     (items.action),
    .stat       (stat),
    .cmd        (cmd)
  );

  dlc_datapath #(
    .MAX_TAPS (MAX_TAPS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .action          (items.action),
    .tap_index       (items.tap_index),
    .value           (items.value),
    .first_of_signal (items.first_of_signal),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .out_value       (results.out_value)
  );

endmodule

### hw/rtl/dlc_ctrl.sv
// dlc_ctrl: sequencing state machine of the convolution block.
// Drives datapath commands from item transfers and datapath status. Depends on dlc_pkg.
`timescale 1ns / 1ps

module dlc_ctrl import dlc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  action_t   action,
  input  dlc_stat_t stat,
  output dlc_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          unique case (action)
            ACT_LOAD: begin
              cmd.load_tap = 1'b1;
            end
            ACT_PUSH, ACT_FLUSH: begin
              cmd.take   = 1'b1;
              state_next = ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (stat.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.acc_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/dlc_datapath.sv
// dlc_datapath: kernel and history memories, tap counter, multiply-accumulate
// pipeline and output register. Commanded by dlc_ctrl. Depends on dlc_pkg.
`timescale 1ns / 1ps

module dlc_datapath import dlc_pkg::*; #(
  parameter int MAX_TAPS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  dlc_cmd_t   cmd,
  output dlc_stat_t  stat,
  input  logic       cfg_we,
  input  tap_count_t cfg_wdata,
  input  action_t    action,
  input  tap_index_t tap_index,
  input  sample_t    value,
  input  logic       first_of_signal,
  output logic       out_valid,
  input  logic       out_ready,
  output acc_t       out_value
);

  localparam int AW = $clog2(MAX_TAPS);
  localparam int RD = 1 << AW;
  localparam int CW = $clog2(MAX_TAPS + 1);

  tap_count_t      tap_count;
  sample_t         kmem [MAX_TAPS];
  sample_t         hmem [RD];
  logic [RD-1:0]   hvalid;
  logic [AW-1:0]   wp;
  logic [AW-1:0]   m;
  logic [AW-1:0]   raddr;
  logic [CW-1:0]   taps_eff;
  sample_t         x;

  logic            s1_v, s1_first, s1_last, s1_hv;
  sample_t         s1_k, s1_h;
  sample_t         samp;
  logic            s2_v, s2_first, s2_last;
  product_t        prod;
  acc_t            acc;
  logic            acc_done;

  always_comb begin
    priority if (tap_count == '0) begin
      taps_eff = CW'(1);
    end else if (32'(tap_count) > MAX_TAPS) begin
      taps_eff = CW'(MAX_TAPS);
    end else begin
      taps_eff = CW'(tap_count);
    end
  end

  assign raddr           = wp - m;
  assign samp            = s1_first ? x : (s1_hv ? s1_h : '0);
  assign stat.last_issue = (CW'(m) == taps_eff - CW'(1));
  assign stat.acc_done   = acc_done;
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= tap_count_t'(1);
    end else if (cfg_we) begin
      tap_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_tap && (32'(tap_index) < MAX_TAPS)) begin
      kmem[AW'(tap_index)] <= value;
    end
    if (cmd.issue) begin
      s1_k <= kmem[m];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hmem[wp] <= x;
    end
    if (cmd.issue) begin
      s1_h <= hmem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x <= (action == ACT_FLUSH) ? sample_t'(0) : value;
    end
    if (cmd.issue) begin
      s1_hv    <= hvalid[raddr];
      s1_first <= (m == '0);
      s1_last  <= stat.last_issue;
    end
    s2_first <= s1_first;
    s2_last  <= s1_last;
    prod     <= s1_k * samp;
    if (s2_v) begin
      acc <= (s2_first ? acc_t'(0) : acc) + 40'(prod);
    end
    if (cmd.finish) begin
      out_value <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid    <= '0;
      wp        <= '0;
      m         <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      acc_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v     <= cmd.issue;
      s2_v     <= s1_v;
      acc_done <= s2_v && s2_last;
      if (cmd.take) begin
        m <= '0;
        if (first_of_signal) begin
          hvalid <= '0;
        end
      end else if (cmd.issue) begin
        m <= m + AW'(1);
      end
      if (cmd.finish) begin
        hvalid[wp] <= 1'b1;
        wp         <= wp + AW'(1);
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
